>>> rtl/mrpt_pkg.sv
package mrpt_pkg;

    localparam int NumWidth  = 64;
    localparam int BaseCount = 7;
    localparam int CntWidth  = 7;
    localparam int BaseIdxW  = 3;

    typedef logic [NumWidth-1:0] num_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SPLIT,
        ST_BASE,
        ST_BRED,
        ST_POW,
        ST_POWWAIT,
        ST_TEST,
        ST_SQWAIT,
        ST_DONE
    } state_t;

    // Fixed Miller-Rabin bases, valid for all 64-bit candidates.
    function automatic num_t base_of(input logic [BaseIdxW-1:0] idx);
        num_t b;
        case (idx)
            3'd0:    b = num_t'(64'd2);
            3'd1:    b = num_t'(64'd325);
            3'd2:    b = num_t'(64'd9375);
            3'd3:    b = num_t'(64'd28178);
            3'd4:    b = num_t'(64'd450775);
            3'd5:    b = num_t'(64'd9780504);
            default: b = num_t'(64'd1795265022);
        endcase
        return b;
    endfunction

endpackage

>>> rtl/mrpt_mulmod.sv
// Bit-serial (x * y) mod m, one multiplier bit per cycle, MSB first.
// Operands x and y must already be below m.
module mrpt_mulmod (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  mrpt_pkg::num_t  x,
    input  mrpt_pkg::num_t  y,
    input  mrpt_pkg::num_t  m,
    output logic            done,
    output mrpt_pkg::num_t  result
);

    localparam int W = mrpt_pkg::NumWidth;

    logic                          busy_reg, busy_next;
    logic [mrpt_pkg::CntWidth-1:0] cnt_reg, cnt_next;
    mrpt_pkg::num_t                acc_reg, acc_next;
    mrpt_pkg::num_t                x_reg, x_next;
    mrpt_pkg::num_t                y_reg, y_next;
    mrpt_pkg::num_t                m_reg, m_next;
    logic                          done_reg, done_next;

    logic [W:0] dbl;
    logic [W:0] dbl_red;
    logic [W:0] add;

    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        add     = dbl_red + {1'b0, x_reg};
        if (add >= {1'b0, m_reg})
        begin
            add = add - {1'b0, m_reg};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = mrpt_pkg::CntWidth'(W);
            acc_next  = '0;
            x_next    = x;
            y_next    = y;
            m_next    = m;
        end
        else if (busy_reg)
        begin
            acc_next = y_reg[W-1] ? add[W-1:0] : dbl_red[W-1:0];
            y_next   = {y_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mrpt_pkg::CntWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

>>> rtl/miller_rabin_prime_test_64_top.sv
// Deterministic Miller-Rabin primality test for unsigned 64-bit numbers.
// Input channel s_axis: tdata carries the candidate; one item per test.
// Output channel m_axis: tdata bit 0 is high for a prime; one item per input.
// The block tests one candidate at a time. s_axis_tready is high only while
// idle with no result pending; the result sits in an output register until
// m_axis_tready takes it, and the next candidate is accepted from the cycle after.
// Each modular multiply runs on one bit-serial unit. Per base: a base
// reduction by shift-and-subtract, then one multiply and one squaring per
// bit of d, then up to s-1 squarings. Even inputs and inputs below 4 skip
// the test and go straight to the result.
// Reset clears the FSM state and drops any pending result; no memory
// needs clearing. A stalled receiver holds the result and the input side
// stays closed until the result is taken.
module miller_rabin_prime_test_64_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] number
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] prime flag, [7:1] zero
);

    localparam int W = mrpt_pkg::NumWidth;

    mrpt_pkg::state_t state_reg, state_next;

    mrpt_pkg::num_t n_reg, n_next;
    mrpt_pkg::num_t d_reg, d_next;
    mrpt_pkg::num_t e_reg, e_next;
    mrpt_pkg::num_t a_reg, a_next;
    mrpt_pkg::num_t r_reg, r_next;
    logic [mrpt_pkg::CntWidth-1:0] s_reg, s_next;
    logic [mrpt_pkg::CntWidth-1:0] k_reg, k_next;
    logic [mrpt_pkg::BaseIdxW-1:0] bi_reg, bi_next;
    logic [1:0] ph_reg, ph_next;     // 0: multiply r*a, 1: square a
    logic       prime_reg, prime_next;
    logic       ovalid_reg, ovalid_next;
    logic       res_reg, res_next;

    logic           mm_start;
    mrpt_pkg::num_t mm_x, mm_y;
    logic           mm_done;
    mrpt_pkg::num_t mm_res;
    mrpt_pkg::num_t nm1;

    assign nm1 = n_reg - 1'b1;

    mrpt_mulmod u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .x      (mm_x),
        .y      (mm_y),
        .m      (n_reg),
        .done   (mm_done),
        .result (mm_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrpt_pkg::ST_IDLE:
                if (s_axis_tvalid && s_axis_tready) state_next = mrpt_pkg::ST_CHECK;
            mrpt_pkg::ST_CHECK:
                if (n_reg < 4 || !n_reg[0]) state_next = mrpt_pkg::ST_DONE;
                else state_next = mrpt_pkg::ST_SPLIT;
            mrpt_pkg::ST_SPLIT:
                if (d_reg[0]) state_next = mrpt_pkg::ST_BASE;
            mrpt_pkg::ST_BASE:
                if (32'(bi_reg) >= mrpt_pkg::BaseCount) state_next = mrpt_pkg::ST_DONE;
                else state_next = mrpt_pkg::ST_BRED;
            mrpt_pkg::ST_BRED:
                if (a_reg < n_reg && k_reg == '0)
                    state_next = (a_reg == '0) ? mrpt_pkg::ST_BASE : mrpt_pkg::ST_POW;
            mrpt_pkg::ST_POW:
                if (e_reg == '0) state_next = mrpt_pkg::ST_TEST;
                else state_next = mrpt_pkg::ST_POWWAIT;
            mrpt_pkg::ST_POWWAIT:
                if (mm_done && ph_reg == 2'd1) state_next = mrpt_pkg::ST_POW;
                else if (mm_done) state_next = mrpt_pkg::ST_POWWAIT;
            mrpt_pkg::ST_TEST:
                if ((r_reg == 1 && k_reg == 1) || r_reg == nm1)
                    state_next = mrpt_pkg::ST_BASE;
                else if (k_reg >= s_reg) state_next = mrpt_pkg::ST_DONE;
                else state_next = mrpt_pkg::ST_SQWAIT;
            mrpt_pkg::ST_SQWAIT:
                if (mm_done) state_next = mrpt_pkg::ST_TEST;
            mrpt_pkg::ST_DONE:
                state_next = mrpt_pkg::ST_IDLE;
            default:
                state_next = mrpt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        n_next      = n_reg;
        d_next      = d_reg;
        e_next      = e_reg;
        a_next      = a_reg;
        r_next      = r_reg;
        s_next      = s_reg;
        k_next      = k_reg;
        bi_next     = bi_reg;
        ph_next     = ph_reg;
        prime_next  = prime_reg;
        ovalid_next = ovalid_reg;
        res_next    = res_reg;
        mm_start    = 1'b0;
        mm_x        = r_reg;
        mm_y        = a_reg;
        if (m_axis_tvalid && m_axis_tready) ovalid_next = 1'b0;
        unique case (state_reg)
            mrpt_pkg::ST_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                begin
                    n_next = s_axis_tdata[W-1:0];
                end
            mrpt_pkg::ST_CHECK:
            begin
                prime_next = (n_reg == 2 || n_reg == 3);
                d_next     = nm1;
                s_next     = '0;
                bi_next    = '0;
            end
            mrpt_pkg::ST_SPLIT:
                if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
                else prime_next = 1'b1;
            mrpt_pkg::ST_BASE:
            begin
                a_next = mrpt_pkg::base_of(bi_reg);
                bi_next = bi_reg + 1'b1;
                k_next = mrpt_pkg::CntWidth'(W - 1);
            end
            mrpt_pkg::ST_BRED:
            begin
                // Reduce the base by shift-and-subtract, one bit a cycle.
                if ((a_reg >> k_reg) >= n_reg)
                    a_next = a_reg - (n_reg << k_reg);
                if (k_reg != '0) k_next = k_reg - 1'b1;
                r_next  = mrpt_pkg::num_t'(1);
                e_next  = d_reg;
                ph_next = 2'd0;
            end
            mrpt_pkg::ST_POW:
                if (e_reg == '0) k_next = mrpt_pkg::CntWidth'(1);
                else
                begin
                    mm_start = 1'b1;
                    ph_next  = 2'd0;
                end
            mrpt_pkg::ST_POWWAIT:
                if (mm_done)
                begin
                    if (ph_reg == 2'd0)
                    begin
                        if (e_reg[0]) r_next = mm_res;
                        mm_start = 1'b1;
                        mm_x     = a_reg;
                        ph_next  = 2'd1;
                    end
                    else
                    begin
                        a_next = mm_res;
                        e_next = e_reg >> 1;
                    end
                end
            mrpt_pkg::ST_TEST:
                // A value of 1 passes only before any squaring.
                if ((r_reg == 1 && k_reg == 1) || r_reg == nm1) begin end
                else if (k_reg >= s_reg) prime_next = 1'b0;
                else
                begin
                    mm_start = 1'b1;
                    mm_x     = r_reg;
                    mm_y     = r_reg;
                    k_next   = k_reg + 1'b1;
                end
            mrpt_pkg::ST_SQWAIT:
                if (mm_done)
                begin
                    r_next = mm_res;
                end
            mrpt_pkg::ST_DONE:
            begin
                ovalid_next = 1'b1;
                res_next    = prime_reg;
            end
            default: begin end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mrpt_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
        a_reg     <= a_next;
        r_reg     <= r_next;
        s_reg     <= s_next;
        k_reg     <= k_next;
        bi_reg    <= bi_next;
        ph_reg    <= ph_next;
        prime_reg <= prime_next;
        res_reg   <= res_next;
    end

    assign s_axis_tready = (state_reg == mrpt_pkg::ST_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'd0, res_reg};

`ifndef SYNTHESIS
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input open while a result is pending");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrpt_pkg::ST_DONE) |=> m_axis_tvalid)
        else $error("finished test gave no result");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == mrpt_pkg::ST_CHECK))
        else $error("accepted item not started");
`endif

endmodule

>>> tb/sv/miller_rabin_prime_test_64_top_tb.sv
module miller_rabin_prime_test_64_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 250000;
    localparam int DrainWait  = 200;

    class prime_scoreboard;
        bit verdict_q[$];
        int errors;
        int checked;
        int primes_seen;

        function logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
            logic [127:0] prod;
            prod = {64'd0, a} * {64'd0, b};
            return 64'(prod % {64'd0, m});
        endfunction

        function bit base_ok(logic [63:0] n, logic [63:0] d, int s, logic [63:0] a);
            logic [63:0] x;
            logic [63:0] b;
            logic [63:0] e;
            x = 64'd1;
            b = a;
            e = d;
            while (e != 0) begin
                if (e[0])
                    x = mul_mod(x, b, n);
                b = mul_mod(b, b, n);
                e = e >> 1;
            end
            if (x == 64'd1 || x == n - 64'd1)
                return 1'b1;
            for (int r = 1; r < s; r++) begin
                x = mul_mod(x, x, n);
                if (x == n - 64'd1)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit prime_verdict(logic [63:0] n);
            logic [63:0] d;
            logic [63:0] a;
            int s;
            if (n < 2)
                return 1'b0;
            if (n == 2 || n == 3)
                return 1'b1;
            if (!n[0])
                return 1'b0;
            d = n - 64'd1;
            s = 0;
            while (!d[0]) begin
                d = d >> 1;
                s++;
            end
            for (int i = 0; i < mrpt_pkg::BaseCount; i++) begin
                a = 64'(mrpt_pkg::base_of(mrpt_pkg::BaseIdxW'(i))) % n;
                if (a == 0)
                    continue;
                if (!base_ok(n, d, s, a))
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_candidate(logic [63:0] n);
            verdict_q.push_back(prime_verdict(n));
        endfunction

        function void check_result(logic [7:0] got);
            logic [7:0] want;
            checked++;
            if (verdict_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item: got %h", got);
                return;
            end
            want = {7'd0, verdict_q.pop_front()};
            if (want[0])
                primes_seen++;
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: expected %h, got %h", checked, want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    prime_scoreboard verdicts = new();
    int send_idle_pct;
    int recv_stall_pct;
    int holdoff_cycles;
    int holdoff_seq;
    int quiet_cycles;
    int sent;

    miller_rabin_prime_test_64_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_candidate(input logic [63:0] n);
        int gap;
        gap = 0;
        if (send_idle_pct > 0)
            while ($urandom_range(99) < send_idle_pct && gap < 20)
                gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= n;
        do
            @(posedge clk);
        while (!s_axis_tready);
        verdicts.note_candidate(n);
        sent++;
    endtask

    task automatic wait_drained();
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        while (verdicts.verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // Mostly small operands keep the run short; a share of wide ones toggles every bit.
    function automatic logic [63:0] random_candidate();
        logic [63:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = 64'($urandom_range(4095)) | 64'd1;
            4, 5:       v = 64'($urandom_range(32'hFFFFF));
            6:          v = {$urandom, $urandom};
            7:          v = {$urandom, $urandom} & ~64'd1;
            8:          v = 64'($urandom_range(15));
            default:    v = {1'b1, 31'($urandom), $urandom} | 64'd1;
        endcase
        return v;
    endfunction

    // Receiver: random stalls, or a long hold-off when asked.
    initial begin
        int seen;
        seen = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (holdoff_seq != seen) begin
                seen = holdoff_seq;
                m_axis_tready <= 1'b0;
                repeat (holdoff_cycles) @(posedge clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            verdicts.check_result(m_axis_tdata);
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("watchdog expired with %0d results outstanding",
                     verdicts.verdict_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [63:0] directed [$];
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_cycles = 0;
        holdoff_seq    = 0;
        sent           = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Trivial cases, bases that vanish mod n, strong pseudoprimes, extremes.
        directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd13, 64'd9,
                     64'd561, 64'd2047, 64'd3215031751, 64'd1000000007,
                     64'd3825123056546413051, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFC5, 64'h8000_0000_0000_0000,
                     64'd4294967291, 64'd1795265023, 64'd9780503, 64'd65537};
        foreach (directed[i])
            send_candidate(directed[i]);
        wait_drained();

        // Hold the output so the block fills and closes its input; the first
        // candidate is even so its result is ready well inside the hold-off.
        holdoff_cycles = 3000;
        holdoff_seq++;
        send_candidate(64'd1024);
        for (int i = 0; i < 4; i++)
            send_candidate(random_candidate());
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            for (int i = 0; i < 20; i++)
                send_candidate(random_candidate());
        end
        wait_drained();
        repeat (DrainWait) @(posedge clk);

        $display("tested %0d candidates, %0d reported prime, incl. pseudoprimes and extremes",
                 sent, verdicts.primes_seen);
        $display("mismatches: %0d", verdicts.errors);
        if (verdicts.errors == 0 && verdicts.verdict_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
